/* sv/olads_pkg.sv */
// ----------------------------------------------------------------------------
// olads_pkg: shared types and constants for the ordered list core
// Store depth, derived widths, command and status codes, cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package olads_pkg;

  localparam int DEPTH   = 256;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 8;
  localparam int FPOS_W  = 8;
  localparam int LEN_W   = 9;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Find encoder: groups of GRP_SZ match bits, then a select over groups
  localparam int GRP_SZ  = 16;
  localparam int GRP_W   = $clog2(GRP_SZ);
  localparam int NGRP    = (DEPTH + GRP_SZ - 1) / GRP_SZ;
  localparam int GSEL_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PIDX_W  = GSEL_W + GRP_W;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GRP,
    S_SEL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              append_en;
    logic              delete_en;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/olads_cell.sv */
// ----------------------------------------------------------------------------
// olads_cell: one list slot
// Holds one entry, loads on append at the tail, takes the right neighbor's
// entry on delete at or below its index, and flags a match for find.
// ----------------------------------------------------------------------------
`default_nettype none

module olads_cell (
  input  wire                        clk_i,
  input  olads_pkg::cell_ctl_t       ctl_i,
  input  wire  [olads_pkg::IDX_W-1:0]  idx_i,
  input  wire  [olads_pkg::DATA_W-1:0] next_i,
  output logic [olads_pkg::DATA_W-1:0] entry_o,
  output logic                       match_o
);
  import olads_pkg::*;

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [CMP_W-1:0]  idx_x, cnt_x, pos_x;
  logic              occupied;

  assign idx_x    = CMP_W'(idx_i);
  assign cnt_x    = CMP_W'(ctl_i.count);
  assign pos_x    = CMP_W'(ctl_i.pos);
  assign occupied = idx_x < cnt_x;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.append_en && (idx_x == cnt_x)) begin
      entry_d = ctl_i.value;
    end else if (ctl_i.delete_en && (idx_x >= pos_x)) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = occupied && (entry_q == ctl_i.value);

endmodule

`default_nettype wire

/* sv/olads_find.sv */
// ----------------------------------------------------------------------------
// olads_find: first-match encoder
// Capture the match row, encode each group of slots, then pick the lowest
// group with a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module olads_find (
  input  wire                          clk_i,
  input  wire                          cap_i,
  input  wire  [olads_pkg::DEPTH-1:0]  match_i,
  output logic                         hit_o,
  output logic [olads_pkg::IDX_W-1:0]  idx_o
);
  import olads_pkg::*;

  logic [NGRP*GRP_SZ-1:0] match_q;
  logic [NGRP-1:0]        grp_any_q, grp_any_d;
  logic [GRP_W-1:0]       grp_first_q [NGRP];
  logic [GRP_W-1:0]       grp_first_d [NGRP];
  logic [PIDX_W-1:0]      pidx;

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      match_q <= (NGRP*GRP_SZ)'(match_i);
    end
  end

  // per-group lowest set bit
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g]   = 1'b0;
      grp_first_d[g] = '0;
      for (int b = GRP_SZ - 1; b >= 0; b--) begin
        if (match_q[g*GRP_SZ + b]) begin
          grp_any_d[g]   = 1'b1;
          grp_first_d[g] = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q   <= grp_any_d;
    grp_first_q <= grp_first_d;
  end

  // lowest group with a hit
  always_comb begin
    hit_o = 1'b0;
    pidx  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        hit_o = 1'b1;
        pidx  = {GSEL_W'(g), grp_first_q[g]};
      end
    end
  end

  assign idx_o = IDX_W'(pidx);

endmodule

`default_nettype wire

/* sv/ordered_list_append_delete_search_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_append_delete_search_core: bounded ordered list of 32-bit values
// Append at the tail, delete at a position with gap closing, find the first
// position of a value. One result per command, always carrying the length.
// ----------------------------------------------------------------------------
// Result path: append, delete and unused codes pass through the execute and done
//   states before out_valid_o rises; find adds the group encode and group select states.
// Transactions: the command sequencer works on one command at a time and takes no
//   new one until its result goes to the output register; the output register decouples.
// Reset: list empties at once (length 0); slot contents stay undefined and
//   are never read while beyond the length. No clearing pass.
`default_nettype none

module ordered_list_append_delete_search_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // input channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [1:0]                         command_i,
  input  wire  signed [olads_pkg::DATA_W-1:0] value_i,
  input  wire  [olads_pkg::POS_W-1:0]        position_i,
  // output channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [1:0]                         status_o,
  output logic [olads_pkg::FPOS_W-1:0]       found_position_o,
  output logic [olads_pkg::LEN_W-1:0]        list_length_o
);
  import olads_pkg::*;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;

  // command latched at the input transaction
  logic [1:0]        cmd_q;
  logic [DATA_W-1:0] value_q;
  logic [POS_W-1:0]  pos_q;

  // pending result and output register
  logic [1:0]        res_status_q, res_status_d;
  logic [FPOS_W-1:0] res_fpos_q, res_fpos_d;
  logic [1:0]        out_status_q;
  logic [FPOS_W-1:0] out_fpos_q;
  logic [LEN_W-1:0]  out_len_q;

  logic              in_fire, out_free, load_out;
  logic              is_full, pos_ok;
  cell_ctl_t         ctl;

  // cell row
  logic [DATA_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]  match;
  logic              find_hit;
  logic [IDX_W-1:0]  find_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == S_DONE) && out_free;

  assign is_full = (count_q == CNT_W'(DEPTH));
  assign pos_ok  = CMP_W'(pos_q) < CMP_W'(count_q);

  // Drive the row only in the execute cycle; otherwise the slots hold.
  always_comb begin
    ctl.append_en = (state_q == S_EXEC) && (cmd_q == CMD_APPEND) && !is_full;
    ctl.delete_en = (state_q == S_EXEC) && (cmd_q == CMD_DELETE) && pos_ok;
    ctl.count     = count_q;
    ctl.pos       = pos_q;
    ctl.value     = value_q;
  end

  // --------------------------------------------------------------------------
  // Row of slots: each takes its right neighbor on delete
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (g == DEPTH - 1) begin : g_last
      assign nbr = entry[g];
    end else begin : g_mid
      assign nbr = entry[g+1];
    end
    olads_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (IDX_W'(g)),
      .next_i  (nbr),
      .entry_o (entry[g]),
      .match_o (match[g])
    );
  end

  // capture the match row in the execute cycle of a find
  olads_find u_find (
    .clk_i   (clk_i),
    .cap_i   ((state_q == S_EXEC) && (cmd_q == CMD_FIND)),
    .match_i (match),
    .hit_o   (find_hit),
    .idx_o   (find_idx)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_fpos_d   = res_fpos_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_OK;
        res_fpos_d   = '0;
        state_d      = S_DONE;
        case (cmd_q)
          CMD_APPEND: begin
            if (is_full) begin
              res_status_d = ST_FULL;
            end else begin
              count_d = count_q + CNT_W'(1);
            end
          end
          CMD_DELETE: begin
            if (pos_ok) begin
              count_d = count_q - CNT_W'(1);
            end else begin
              res_status_d = ST_RANGE;
            end
          end
          CMD_FIND: begin
            state_d = S_GRP;
          end
          default: begin
            // unused code: no change, ok
          end
        endcase
      end
      S_GRP: begin
        state_d = S_SEL;
      end
      S_SEL: begin
        if (find_hit) begin
          res_fpos_d = FPOS_W'(find_idx);
        end else begin
          res_status_d = ST_NOTFOUND;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= command_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    res_status_q <= res_status_d;
    res_fpos_q   <= res_fpos_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_fpos_q   <= res_fpos_q;
      out_len_q    <= LEN_W'(count_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_fpos_q;
  assign list_length_o    = out_len_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list length beyond store depth");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && (cmd_q == CMD_APPEND) && !is_full
      |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("append did not grow the list");

  a_find_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEL) && find_hit |-> CMP_W'(find_idx) < CMP_W'(count_q))
    else $error("find hit beyond list length");

  a_miss_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ST_NOTFOUND) |-> out_fpos_q == '0)
    else $error("not-found result carries a position");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken while a command is in flight");

endmodule

`default_nettype wire

/* tb/sv/ordered_list_append_delete_search_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_delete_search_core_tb: self-checking bench for the list core
// Drives append, delete and find commands over the valid/ready input channel.
// A shadow copy of the list predicts every reply. A short table of corner
// cases comes first. Random episodes follow that fill the store to full,
// drain it again and mix all commands. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module ordered_list_append_delete_search_core_tb;
  import olads_pkg::*;

  // Code 3 is not a command; the core must leave the list alone.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 10;
  // The worst case per item adds the find path, a long input gap and a long output
  // stall. Allow several times that for the whole run.
  localparam int CYCLE_LIMIT = 600000;
  // Find is the slowest command. Wait a little past it at the end.
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    status_e             status;
    logic [FPOS_W-1:0]   fpos;
    logic [LEN_W-1:0]    len;
  } outcome_t;

  typedef struct {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] val;
    logic [POS_W-1:0]         pos;
    bit                       typed;   // use reply below instead of prediction
    outcome_t                 reply;
  } cmd_row_t;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [1:0]                command_i;
  logic signed [DATA_W-1:0]  value_i;
  logic [POS_W-1:0]          position_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [1:0]                status_o;
  logic [FPOS_W-1:0]         found_position_o;
  logic [LEN_W-1:0]          list_length_o;

  // Shadow of the list contents and length, advanced on every accepted command
  logic signed [DATA_W-1:0]  shadow_list [DEPTH];
  int                        shadow_len;

  outcome_t                  pending_outcomes [$];
  cmd_row_t                  corner_rows [$];
  int                        mismatch_count;
  int                        cycle_count;
  bit                        steady_run;   // no idling on either side

  ordered_list_append_delete_search_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .list_length_o    (list_length_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one command to the shadow list and return the reply it should give.
  function automatic outcome_t apply_list_command(logic [1:0] cmd,
                                                  logic signed [DATA_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
    outcome_t r;
    int       i;
    bit       hit;
    r.status = ST_OK;
    r.fpos   = '0;
    hit      = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      CMD_DELETE: begin
        if (int'(pos) >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          // Close the gap: every later entry moves one place toward the head
          for (i = int'(pos); i + 1 < shadow_len; i++)
            shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
        end
      end
      CMD_FIND: begin
        // Lowest matching position wins when values repeat
        for (i = 0; i < shadow_len && !hit; i++) begin
          if (shadow_list[i] == val) begin
            hit    = 1'b1;
            r.fpos = FPOS_W'(i);
          end
        end
        if (!hit)
          r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.len = LEN_W'(shadow_len);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_span();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)
      return $urandom_range(1, 3);
    else if (sel < 92)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 60);
  endfunction

  // Values: full random words, a small pool that makes duplicates, the
  // extremes, and single set bits.
  function automatic logic signed [DATA_W-1:0] draw_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45)
      return $urandom;
    else if (sel < 75)
      return $signed(DATA_W'($urandom_range(0, 7))) - 4;
    else if (sel < 90) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end else
      return 32'sh1 <<< $urandom_range(0, DATA_W - 1);
  endfunction

  // Build one random command. Deletes and finds mostly aim at the live part
  // of the list so that they do real work; the rest is noise.
  function automatic cmd_row_t draw_command(mix_e mix);
    cmd_row_t r;
    int       sel;
    int       w_app;
    int       w_del;
    int       w_find;
    case (mix)
      MIX_FILL:  begin w_app = 85; w_del = 4;  w_find = 9;  end
      MIX_DRAIN: begin w_app = 8;  w_del = 85; w_find = 5;  end
      default:   begin w_app = 35; w_del = 30; w_find = 30; end
    endcase
    r.typed = 1'b0;
    r.reply = '0;
    r.val   = draw_value();
    r.pos   = POS_W'($urandom_range(0, 255));
    sel     = $urandom_range(0, 99);
    if (sel < w_app) begin
      r.cmd = CMD_APPEND;
    end else if (sel < w_app + w_del) begin
      r.cmd = CMD_DELETE;
      if (shadow_len > 0 && $urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 4))
          0:       r.pos = '0;
          1:       r.pos = POS_W'(shadow_len - 1);
          2:       r.pos = POS_W'(shadow_len);   // one past the tail
          default: r.pos = POS_W'($urandom_range(0, shadow_len - 1));
        endcase
      end
    end else if (sel < w_app + w_del + w_find) begin
      r.cmd = CMD_FIND;
      if (shadow_len > 0 && $urandom_range(0, 99) < 70)
        r.val = shadow_list[$urandom_range(0, shadow_len - 1)];
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  function automatic cmd_row_t corner(logic [1:0] cmd, logic signed [DATA_W-1:0] val,
                                      logic [POS_W-1:0] pos, bit typed = 1'b0,
                                      status_e st = ST_OK, int fp = 0, int ln = 0);
    cmd_row_t r;
    r.cmd          = cmd;
    r.val          = val;
    r.pos          = pos;
    r.typed        = typed;
    r.reply.status = st;
    r.reply.fpos   = FPOS_W'(fp);
    r.reply.len    = LEN_W'(ln);
    return r;
  endfunction

  // Present one transaction and hold it until accepted. Outside steady runs the
  // gap before it is random; valid stays high across back-to-back transactions.
  task automatic send_command(cmd_row_t row);
    outcome_t predicted;
    int       gap;
    gap = 0;
    if (!steady_run && $urandom_range(0, 99) >= 40)
      gap = idle_span();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= row.cmd;
    value_i    <= row.val;
    position_i <= row.pos;
    do @(posedge clk_i); while (!in_ready_o);
    // Accepted at this edge: advance the shadow list and queue the reply
    predicted = apply_list_command(row.cmd, row.val, row.pos);
    pending_outcomes.push_back(row.typed ? row.reply : predicted);
  endtask

  task automatic run_episode(mix_e mix, int count, bit steady);
    int n;
    steady_run = steady;
    for (n = 0; n < count; n++)
      send_command(draw_command(mix));
  endtask

  // Output side: stall at random, but stay ready throughout steady episodes.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (steady_run) begin
        out_ready_i <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 25)
          stall_left = idle_span();
      end
    end
  end

  // Check every accepted reply against the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("reply with nothing expected: status %0d found_position %0d length %0d",
               status_o, found_position_o, list_length_o);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (found_position_o !== want.fpos) begin
          $error("found_position: expected %0d, got %0d", want.fpos, found_position_o);
          mismatch_count++;
        end
        if (list_length_o !== want.len) begin
          $error("list_length: expected %0d, got %0d", want.len, list_length_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run with a failure once the cycle limit is reached.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ordered_list_append_delete_search_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_APPEND;
    value_i        = '0;
    position_i     = '0;
    steady_run     = 1'b0;
    shadow_len     = 0;
    mismatch_count = 0;
    cycle_count    = 0;

    // Corner cases. Empty-list errors and the extremes have their replies
    // written out; the rest go through the shadow list.
    corner_rows.push_back(corner(CMD_FIND,   0, 0,   1, ST_NOTFOUND, 0, 0));
    corner_rows.push_back(corner(CMD_DELETE, 0, 0,   1, ST_RANGE,    0, 0));
    corner_rows.push_back(corner(CMD_DELETE, 0, 255, 1, ST_RANGE,    0, 0));
    corner_rows.push_back(corner(CMD_UNUSED, -1, 255, 1, ST_OK,      0, 0));
    corner_rows.push_back(corner(CMD_APPEND, 32'sh8000_0000, 0, 1, ST_OK, 0, 1));
    corner_rows.push_back(corner(CMD_APPEND, 32'sh7FFF_FFFF, 255, 1, ST_OK, 0, 2));
    corner_rows.push_back(corner(CMD_APPEND, 0,  0));
    corner_rows.push_back(corner(CMD_APPEND, -1, 0));
    corner_rows.push_back(corner(CMD_APPEND, 32'sh7FFF_FFFF, 0));   // duplicate
    corner_rows.push_back(corner(CMD_FIND, 32'sh7FFF_FFFF, 0, 1, ST_OK, 1, 5));
    corner_rows.push_back(corner(CMD_FIND, 32'sh8000_0000, 0, 1, ST_OK, 0, 5));
    corner_rows.push_back(corner(CMD_FIND, -1, 0));
    corner_rows.push_back(corner(CMD_FIND, 1,  0));
    corner_rows.push_back(corner(CMD_DELETE, 0, 5,   1, ST_RANGE, 0, 5));
    corner_rows.push_back(corner(CMD_DELETE, 0, 255, 1, ST_RANGE, 0, 5));
    corner_rows.push_back(corner(CMD_UNUSED, 32'sh5A5A_A5A5, 3, 1, ST_OK, 0, 5));
    corner_rows.push_back(corner(CMD_DELETE, 0, 1));   // drop first duplicate
    corner_rows.push_back(corner(CMD_FIND, 32'sh7FFF_FFFF, 0));
    corner_rows.push_back(corner(CMD_DELETE, 0, 3));   // drop the tail
    corner_rows.push_back(corner(CMD_DELETE, 0, 0));   // drop the head
    corner_rows.push_back(corner(CMD_FIND, 32'sh5555_5555, 170));
    corner_rows.push_back(corner(CMD_APPEND, 32'shAAAA_AAAA, 85));
    corner_rows.push_back(corner(CMD_FIND, 32'shAAAA_AAAA, 0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_rows[k])
      send_command(corner_rows[k]);

    // Random episodes: fill the store past full, drain it, and mix in between
    run_episode(MIX_BALANCED, 150, 1'b0);
    run_episode(MIX_FILL,     330, 1'b0);
    run_episode(MIX_BALANCED, 100, 1'b1);
    run_episode(MIX_DRAIN,    330, 1'b0);
    run_episode(MIX_BALANCED, 150, 1'b1);
    run_episode(MIX_FILL,      90, 1'b0);

    in_valid_i <= 1'b0;
    steady_run = 1'b0;
    while (pending_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);

    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("ordered_list_append_delete_search_core_tb: PASS");
    else
      $display("ordered_list_append_delete_search_core_tb: FAIL");
    $finish;
  end

endmodule
